// ===== design/cgpm_pkg.sv =====
package cgpm_pkg;

    // Polynomial length in coefficients; a multiple of the word width.
    localparam int POLY_BITS  = 256;
    localparam int WORD_W     = 64;
    localparam int POLY_WORDS = POLY_BITS / WORD_W;

    localparam int SLOT_W     = (POLY_WORDS > 1) ? $clog2(POLY_WORDS) : 1;
    localparam int STEP_W     = $clog2(POLY_BITS);
    localparam int IN_DATA_W  = 2 * WORD_W;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load_en;
        logic [SLOT_W-1:0] slot;
        logic              prep;
        logic              step;
        logic              shift_out;
    } cgpm_cmd_t;

endpackage

// ===== design/cgpm_ctrl.sv =====
module cgpm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tlast,
    output logic               s_tready,
    output logic               m_tvalid,
    output logic               m_tlast,
    input  logic               m_tready,
    output cgpm_pkg::cgpm_cmd_t cmd
);
    import cgpm_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_PREP = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SLOT_W-1:0]   out_reg, out_next;
    logic                slot_wrap;
    logic                out_last;

    assign slot_wrap = (slot_reg == SLOT_W'(POLY_WORDS - 1));
    assign out_last  = (out_reg == SLOT_W'(POLY_WORDS - 1));

    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        step_next     = step_reg;
        out_next      = out_reg;
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        m_tlast       = 1'b0;
        cmd.load_en   = 1'b0;
        cmd.slot      = slot_reg;
        cmd.prep      = 1'b0;
        cmd.step      = 1'b0;
        cmd.shift_out = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_en = 1'b1;
                    if (s_tlast)
                    begin
                        slot_next  = '0;
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        slot_next = slot_wrap ? '0 : slot_reg + 1'b1;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(POLY_BITS - 1))
                begin
                    out_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                m_tlast  = out_last;
                if (m_tready)
                begin
                    cmd.shift_out = 1'b1;
                    out_next      = out_reg + 1'b1;
                    if (out_last)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            slot_reg  <= '0;
            step_reg  <= '0;
            out_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            step_reg  <= step_next;
            out_reg   <= out_next;
        end
    end

endmodule

// ===== design/cgpm_datapath.sv =====
module cgpm_datapath (
    input  logic                         clk,
    input  cgpm_pkg::cgpm_cmd_t          cmd,
    input  logic [cgpm_pkg::WORD_W-1:0]  a_word,
    input  logic [cgpm_pkg::WORD_W-1:0]  b_word,
    output logic [cgpm_pkg::WORD_W-1:0]  product_word
);
    import cgpm_pkg::*;

    logic [POLY_BITS-1:0] a_store_reg, a_store_next;
    logic [POLY_BITS-1:0] b_store_reg, b_store_next;
    logic [POLY_BITS-1:0] a_work_reg, a_work_next;
    logic [POLY_BITS-1:0] b_work_reg, b_work_next;
    logic [POLY_BITS-1:0] acc_reg, acc_next;

    always_comb
    begin
        a_store_next = a_store_reg;
        b_store_next = b_store_reg;
        for (int w = 0; w < POLY_WORDS; w++)
        begin
            if (cmd.load_en && (cmd.slot == SLOT_W'(w)))
            begin
                a_store_next[w*WORD_W +: WORD_W] = a_word;
                b_store_next[w*WORD_W +: WORD_W] = b_word;
            end
        end
    end

    // Working copies: a shifts right so its next coefficient sits in bit 0,
    // b rotates left one place per step.
    always_comb
    begin
        a_work_next = a_work_reg;
        b_work_next = b_work_reg;
        acc_next    = acc_reg;
        if (cmd.prep)
        begin
            a_work_next = a_store_reg;
            b_work_next = b_store_reg;
            acc_next    = '0;
        end
        else if (cmd.step)
        begin
            a_work_next = a_work_reg >> 1;
            b_work_next = {b_work_reg[POLY_BITS-2:0], b_work_reg[POLY_BITS-1]};
            acc_next    = acc_reg ^ (b_work_reg & {POLY_BITS{a_work_reg[0]}});
        end
        else if (cmd.shift_out)
        begin
            acc_next = acc_reg >> WORD_W;
        end
    end

    always_ff @(posedge clk)
    begin
        a_store_reg <= a_store_next;
        b_store_reg <= b_store_next;
        a_work_reg  <= a_work_next;
        b_work_reg  <= b_work_next;
        acc_reg     <= acc_next;
    end

    assign product_word = acc_reg[WORD_W-1:0];

endmodule

// ===== design/cyclic_gf2_poly_multiplier_core.sv =====
// Cyclic GF(2) polynomial multiplier: computes a*b modulo x^POLY_BITS - 1
// (the cyclic convolution of two binary polynomials). Operand words enter
// on the slave side lowest word first, a and b side by side in one item;
// tlast on the final word starts the multiplication. A run with the default
// POLY_BITS of 256 loads POLY_BITS/64 words, passes through a preparation
// state, performs POLY_BITS shift-and-XOR steps (one coefficient of a per
// cycle through the single rotate-and-accumulate unit in the datapath) and
// emits POLY_BITS/64 product words. The input is not ready from the final
// load word until the last product word has been taken.
// More than POLY_BITS/64 words without tlast wrap round and overwrite the
// earliest slots; an early tlast reuses what the other slots still hold.
module cyclic_gf2_poly_multiplier_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // s_tdata fields from bit 0: a_word[63:0], b_word[63:0]
    input  logic [cgpm_pkg::IN_DATA_W-1:0] s_tdata,
    // s_tlast: load_last
    input  logic                           s_tlast,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // m_tdata fields from bit 0: product_word[63:0]
    output logic [cgpm_pkg::WORD_W-1:0]    m_tdata,
    // m_tlast: product_last
    output logic                           m_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready
);
    import cgpm_pkg::*;

    cgpm_cmd_t cmd;

    // The controller sequences loading, the bit-serial run and the output.
    cgpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // The datapath holds the operand stores, the working rotations and the
    // accumulator, which also serves as the output register.
    cgpm_datapath u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .a_word       (s_tdata[WORD_W-1:0]),
        .b_word       (s_tdata[IN_DATA_W-1:WORD_W]),
        .product_word (m_tdata)
    );

    // Loading and output never overlap.
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input ready while a product word is offered");

    // A final load word is followed by the preparation state, not by a
    // further load or an early output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (!s_tready && !m_tvalid))
        else $error("run did not start after the final load word");

    // Taking the final product word returns the block to loading.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("block did not return to loading after the last word");

    // Only the datapath command for one phase is issued at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_en, cmd.prep, cmd.step, cmd.shift_out}))
        else $error("conflicting datapath commands");

endmodule

// ===== sim/testbench.sv =====
module testbench;

    import cgpm_pkg::*;

    // One product word as it should leave the master side.
    typedef struct {
        logic [WORD_W-1:0] word;
        logic              last;
    } product_item_t;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic [IN_DATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [WORD_W-1:0]    m_tdata;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    // Shadow copy of the operand stores and the load pointer.
    logic [WORD_W-1:0] a_slots [POLY_WORDS];
    logic [WORD_W-1:0] b_slots [POLY_WORDS];
    int                next_slot = 0;

    product_item_t     product_q [$];
    int                mismatch_count = 0;
    bit                idle_on = 1'b1;
    int                stall_left = 0;

    cyclic_gf2_poly_multiplier_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Product of a and b modulo x^POLY_BITS - 1: every set coefficient of a
    // adds the matching cyclic rotation of b.
    function automatic logic [POLY_BITS-1:0] cyclic_product(input logic [POLY_BITS-1:0] a,
                                                            input logic [POLY_BITS-1:0] b);
        logic [POLY_BITS-1:0] rot;
        logic [POLY_BITS-1:0] acc;
        rot = b;
        acc = '0;
        for (int i = 0; i < POLY_BITS; i++)
        begin
            if (a[i])
                acc ^= rot;
            rot = {rot[POLY_BITS-2:0], rot[POLY_BITS-1]};
        end
        return acc;
    endfunction

    // Updates the shadow stores for one accepted operand item; the final word
    // of a run queues the whole product, lowest word first.
    function automatic void take_operand_word(input logic [WORD_W-1:0] a_word,
                                              input logic [WORD_W-1:0] b_word,
                                              input logic              load_last);
        logic [POLY_BITS-1:0] a_vec;
        logic [POLY_BITS-1:0] b_vec;
        logic [POLY_BITS-1:0] prod;
        product_item_t        item;
        a_slots[next_slot] = a_word;
        b_slots[next_slot] = b_word;
        if (!load_last)
        begin
            next_slot = (next_slot + 1) % POLY_WORDS;
            return;
        end
        for (int w = 0; w < POLY_WORDS; w++)
        begin
            a_vec[w*WORD_W +: WORD_W] = a_slots[w];
            b_vec[w*WORD_W +: WORD_W] = b_slots[w];
        end
        prod = cyclic_product(a_vec, b_vec);
        for (int w = 0; w < POLY_WORDS; w++)
        begin
            item.word = prod[w*WORD_W +: WORD_W];
            item.last = (w == POLY_WORDS - 1);
            product_q.push_back(item);
        end
        next_slot = 0;
    endfunction

    // Mostly dense random words, with a share of empty, full, single-bit and
    // single-zero patterns so that sparse products and terms across words show up.
    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] one_hot;
        one_hot = 64'd1 << $urandom_range(0, WORD_W - 1);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offers one operand item, with an occasional idle burst beforehand, and
    // returns at the falling edge after it has been taken.
    task automatic send_word(input logic [WORD_W-1:0] a_word,
                             input logic [WORD_W-1:0] b_word,
                             input logic              load_last);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_tdata  <= {b_word, a_word};
        s_tlast  <= load_last;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        take_operand_word(a_word, b_word, load_last);
        @(negedge clk);
    endtask

    // A complete, well-formed run: every slot loaded, tlast on the top word.
    task automatic send_operands(input logic [POLY_BITS-1:0] a, input logic [POLY_BITS-1:0] b);
        for (int w = 0; w < POLY_WORDS; w++)
            send_word(a[w*WORD_W +: WORD_W], b[w*WORD_W +: WORD_W], w == POLY_WORDS - 1);
    endtask

    // The first run here fills every slot, so no later early tlast can pick up
    // a slot that has never been loaded.
    task automatic test_directed_products();
        logic [POLY_BITS-1:0] rnd;
        for (int w = 0; w < POLY_WORDS; w++)
            rnd[w*WORD_W +: WORD_W] = {$urandom, $urandom};
        send_operands('0, '1);
        send_operands('1, '1);
        send_operands({{(POLY_BITS-1){1'b0}}, 1'b1}, rnd);
        // The top coefficient of a times x wraps round to the constant term.
        send_operands({1'b1, {(POLY_BITS-1){1'b0}}}, {{(POLY_BITS-2){1'b0}}, 2'b10});
    endtask

    task automatic test_early_last();
        send_word(pick_word(), pick_word(), 1'b1);
        send_word(pick_word(), pick_word(), 1'b0);
        send_word(pick_word(), pick_word(), 1'b1);
    endtask

    // Six words without an earlier tlast: the pointer wraps and the first two
    // slots are overwritten before the run starts.
    task automatic test_word_wrap();
        for (int k = 0; k < POLY_WORDS + 2; k++)
            send_word(pick_word(), pick_word(), k == POLY_WORDS + 1);
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(0, 9))
                7:       len = $urandom_range(1, POLY_WORDS - 1);
                8:       len = $urandom_range(POLY_WORDS + 1, 2 * POLY_WORDS + 1);
                default: len = POLY_WORDS;
            endcase
            for (int k = 0; k < len; k++)
                send_word(pick_word(), pick_word(), k == len - 1);
            sent += len;
        end
    endtask

    task automatic test_back_to_back(input int n_items);
        for (int k = 0; k < n_items; k += POLY_WORDS)
            for (int w = 0; w < POLY_WORDS; w++)
                send_word(pick_word(), pick_word(), w == POLY_WORDS - 1);
    endtask

    // Sink side: ready is held low in random bursts while idling is enabled.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 18);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Every product item is matched against the oldest word still expected.
    always @(posedge clk)
    begin : check_products
        product_item_t want;
        if (m_tvalid && m_tready)
        begin
            if (product_q.size() == 0)
            begin
                $display("%0t: product item with none expected, data %h last %b",
                         $time, m_tdata, m_tlast);
                mismatch_count++;
            end
            else
            begin
                want = product_q.pop_front();
                if (m_tdata !== want.word)
                begin
                    $display("%0t: product word expected %h actual %h",
                             $time, want.word, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: product last expected %b actual %b",
                             $time, want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_products();
        test_early_last();
        test_word_wrap();
        test_random_traffic(96);
        idle_on = 1'b0;
        test_back_to_back(32);
        s_tvalid <= 1'b0;
        while (product_q.size() != 0)
            @(negedge clk);
        repeat (POLY_BITS + 2 * POLY_WORDS + 8) @(negedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
